[design/ogbu_pkg.sv]
// ----------------------------------------------------------------------------
// ogbu_pkg
// Shared widths, codes and defaults of the occupancy grid update block.
// ----------------------------------------------------------------------------
package ogbu_pkg;

  // Field widths
  localparam int PROB_W     = 16;  // Q0.16 probability
  localparam int INDEX_W    = 14;  // global cell index on the ports
  localparam int POS_W      = 8;   // pose coordinate
  localparam int CMD_W      = 2;
  localparam int SENSE_W    = 2;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Signed coordinate width: pose up to 255 plus a local offset up to 63,
  // minus half a local window, compared against a grid side up to 1024.
  localparam int COORD_W = 12;

  typedef logic [PROB_W-1:0] prob_t;

  // Parameter defaults
  localparam int GRID_WIDTH_DEF   = 128;
  localparam int GRID_HEIGHT_DEF  = 128;
  localparam int LOCAL_WIDTH_DEF  = 16;
  localparam int LOCAL_HEIGHT_DEF = 16;

  // Register reset values
  localparam prob_t PROB_OCC_RST = 16'd45875;
  localparam prob_t PROB_EMP_RST = 16'd19661;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROB_OCC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROB_EMP = 2'd1;

  // Commands
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POSE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LOCAL = 2'd3;

  // Sensor readings (codes two and three both mean unknown)
  localparam logic [SENSE_W-1:0] SENSE_EMPTY = 2'd0;
  localparam logic [SENSE_W-1:0] SENSE_OCC   = 2'd1;

  // Result status
  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_POSE_REJ  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_POSE   = 3'd4;

endpackage

[design/occupancy_grid_bayes_update.sv]
// ----------------------------------------------------------------------------
// occupancy_grid_bayes_update
// Global occupancy grid with host access and Bayes update from local scans.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken on a rising edge with start high and
//   busy low. cmd selects write cell, read cell, set pose or local cell.
//   Each item gives one result on status_o/out_index_o/out_prob_o/
//   scan_last_o, shown for exactly one cycle with done_o high. The receiver
//   has no backpressure and must take it then.
//   Write, pose, no-pose and out-of-range host items give their result
//   in the cycle after the accepting edge. A read passes S_RDOUT; a local
//   cell passes S_INDEX, where one outside the grid or unknown ends; an
//   update goes on through S_FETCH, S_CALC and S_WAIT.
//   The update time is set by the shared multiply/divide unit: two passes
//   through one multiplier, then 17 restoring divide steps, one quotient
//   bit per cycle. busy stays high until the result cycle, so a new item
//   can be taken in the cycle its predecessor's result is shown.
//   Config channel: cfg_valid_i/cfg_ready_o, always ready; index 0 is the
//   occupied-reading probability, index 1 the empty one, other indexes are
//   ignored. Write only while the block is idle.
//   Reset clears pose, scan position and loads the default probabilities.
//   The grid memory is not cleared; host writes it before use.
// ----------------------------------------------------------------------------
module occupancy_grid_bayes_update #(
  parameter int GRID_WIDTH   = ogbu_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT  = ogbu_pkg::GRID_HEIGHT_DEF,
  parameter int LOCAL_WIDTH  = ogbu_pkg::LOCAL_WIDTH_DEF,
  parameter int LOCAL_HEIGHT = ogbu_pkg::LOCAL_HEIGHT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [ogbu_pkg::CMD_W-1:0]          cmd_i,
  input  logic [ogbu_pkg::INDEX_W-1:0]        cell_index_i,
  input  ogbu_pkg::prob_t                     cell_prob_i,
  input  logic [ogbu_pkg::POS_W-1:0]          pose_x_i,
  input  logic [ogbu_pkg::POS_W-1:0]          pose_y_i,
  input  logic [ogbu_pkg::SENSE_W-1:0]        sense_i,
  // result strobe
  output logic                                done_o,
  output logic [ogbu_pkg::STATUS_W-1:0]       status_o,
  output logic [ogbu_pkg::INDEX_W-1:0]        out_index_o,
  output ogbu_pkg::prob_t                     out_prob_o,
  output logic                                scan_last_o,
  // config channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ogbu_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ogbu_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int GRID_CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW         = $clog2(GRID_CELLS);
  localparam int LCW        = $clog2(LOCAL_WIDTH);
  localparam int LRW        = $clog2(LOCAL_HEIGHT);
  localparam int CW         = ogbu_pkg::COORD_W;
  localparam int IW         = ogbu_pkg::INDEX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDOUT = 3'd1;  // read data arrives
  localparam logic [2:0] S_INDEX = 3'd2;  // clip and form grid index
  localparam logic [2:0] S_FETCH = 3'd3;  // read prior
  localparam logic [2:0] S_CALC  = 3'd4;  // launch Bayes unit
  localparam logic [2:0] S_WAIT  = 3'd5;  // wait, then write back

  // control state
  logic [2:0]     state_q, state_d;
  logic           pose_valid_q, pose_valid_d;
  logic [LCW-1:0] local_col_q, local_col_d;
  logic [LRW-1:0] local_row_q, local_row_d;
  logic           done_q, done_d;
  ogbu_pkg::prob_t prob_occ_q, prob_emp_q;

  // payload
  logic [ogbu_pkg::POS_W-1:0]    robot_x_q, robot_x_d, robot_y_q, robot_y_d;
  logic signed [CW-1:0]          gx_q, gx_d, gy_q, gy_d;
  logic [ogbu_pkg::SENSE_W-1:0]  sense_q, sense_d;
  logic                          last_q, last_d;
  logic [AW-1:0]                 g_q, g_d;
  logic [IW-1:0]                 cidx_q, cidx_d;
  logic [ogbu_pkg::STATUS_W-1:0] status_q, status_d;
  logic [IW-1:0]                 oidx_q, oidx_d;
  ogbu_pkg::prob_t               oprob_q, oprob_d;
  logic                          olast_q, olast_d;

  // memory and Bayes unit hookup
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  ogbu_pkg::prob_t ram_wdata, ram_rdata;
  logic            bayes_start, bayes_done;
  ogbu_pkg::prob_t bayes_pa, bayes_pb, bayes_np;

  logic accept, host_in_range, pose_rej, at_col_end, at_row_end;
  logic x_out, y_out;
  logic [AW-1:0] g_calc;

  assign accept        = start && !busy;
  assign host_in_range = 32'(cell_index_i) < 32'(GRID_CELLS);
  assign pose_rej      = ((CW-1)'(pose_x_i) > (CW-1)'(GRID_WIDTH)) ||
                         ((CW-1)'(pose_y_i) > (CW-1)'(GRID_HEIGHT));
  assign at_col_end    = local_col_q == LCW'(LOCAL_WIDTH - 1);
  assign at_row_end    = local_row_q == LRW'(LOCAL_HEIGHT - 1);

  // Clip test on the signed global coordinates of the current local cell.
  assign x_out  = gx_q[CW-1] || (gx_q[CW-2:0] >= (CW-1)'(GRID_WIDTH));
  assign y_out  = gy_q[CW-1] || (gy_q[CW-2:0] >= (CW-1)'(GRID_HEIGHT));
  assign g_calc = AW'(gy_q[CW-2:0]) * AW'(GRID_WIDTH) + AW'(gx_q[CW-2:0]);

  // Occupied reading uses (Pocc, Pemp); empty reading swaps them.
  assign bayes_pa = (sense_q == ogbu_pkg::SENSE_OCC) ? prob_occ_q : prob_emp_q;
  assign bayes_pb = (sense_q == ogbu_pkg::SENSE_OCC) ? prob_emp_q : prob_occ_q;

  always_comb begin
    state_d      = state_q;
    pose_valid_d = pose_valid_q;
    local_col_d  = local_col_q;
    local_row_d  = local_row_q;
    robot_x_d    = robot_x_q;
    robot_y_d    = robot_y_q;
    gx_d         = gx_q;
    gy_d         = gy_q;
    sense_d      = sense_q;
    last_d       = last_q;
    g_d          = g_q;
    cidx_d       = cidx_q;
    done_d       = 1'b0;
    status_d     = status_q;
    oidx_d       = oidx_q;
    oprob_d      = oprob_q;
    olast_d      = olast_q;
    ram_we       = 1'b0;
    ram_waddr    = AW'(cell_index_i);
    ram_wdata    = cell_prob_i;
    ram_re       = 1'b0;
    ram_raddr    = AW'(cell_index_i);
    bayes_start  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_i)
            ogbu_pkg::CMD_WRITE, ogbu_pkg::CMD_READ: begin
              done_d   = 1'b1;
              status_d = host_in_range ? ogbu_pkg::ST_DONE : ogbu_pkg::ST_OUTSIDE;
              oidx_d   = cell_index_i;
              oprob_d  = '0;
              olast_d  = 1'b0;
              if (host_in_range && cmd_i == ogbu_pkg::CMD_WRITE) begin
                ram_we  = 1'b1;
                oprob_d = cell_prob_i;
              end
              if (host_in_range && cmd_i == ogbu_pkg::CMD_READ) begin
                ram_re  = 1'b1;
                done_d  = 1'b0;
                cidx_d  = cell_index_i;
                state_d = S_RDOUT;
              end
            end
            ogbu_pkg::CMD_POSE: begin
              local_col_d = '0;
              local_row_d = '0;
              done_d      = 1'b1;
              oidx_d      = '0;
              oprob_d     = '0;
              olast_d     = 1'b0;
              if (pose_rej) begin
                pose_valid_d = 1'b0;
                status_d     = ogbu_pkg::ST_POSE_REJ;
              end else begin
                pose_valid_d = 1'b1;
                robot_x_d    = pose_x_i;
                robot_y_d    = pose_y_i;
                status_d     = ogbu_pkg::ST_DONE;
              end
            end
            default: begin  // local scan cell
              if (!pose_valid_q) begin
                done_d   = 1'b1;
                status_d = ogbu_pkg::ST_NO_POSE;
                oidx_d   = '0;
                oprob_d  = '0;
                olast_d  = 1'b0;
              end else begin
                gx_d    = CW'(robot_x_q) - CW'(LOCAL_WIDTH / 2) + CW'(local_col_q);
                gy_d    = CW'(robot_y_q) - CW'(LOCAL_HEIGHT / 2) + CW'(local_row_q);
                sense_d = sense_i;
                last_d  = at_col_end && at_row_end;
                // raster advance with wrap at scan end
                if (at_col_end) begin
                  local_col_d = '0;
                  local_row_d = at_row_end ? '0 : local_row_q + 1'b1;
                end else begin
                  local_col_d = local_col_q + 1'b1;
                end
                state_d = S_INDEX;
              end
            end
          endcase
        end
      end
      S_RDOUT: begin
        done_d   = 1'b1;
        status_d = ogbu_pkg::ST_DONE;
        oidx_d   = cidx_q;
        oprob_d  = ram_rdata;
        olast_d  = 1'b0;
        state_d  = S_IDLE;
      end
      S_INDEX: begin
        g_d     = g_calc;
        olast_d = last_q;
        oprob_d = '0;
        if (x_out || y_out) begin
          done_d   = 1'b1;
          status_d = ogbu_pkg::ST_OUTSIDE;
          oidx_d   = '0;
          state_d  = S_IDLE;
        end else if (sense_q[1]) begin
          done_d   = 1'b1;
          status_d = ogbu_pkg::ST_UNKNOWN;
          oidx_d   = IW'(g_calc);
          state_d  = S_IDLE;
        end else begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        ram_re    = 1'b1;
        ram_raddr = g_q;
        state_d   = S_CALC;
      end
      S_CALC: begin
        bayes_start = 1'b1;
        state_d     = S_WAIT;
      end
      S_WAIT: begin
        if (bayes_done) begin
          ram_we    = 1'b1;
          ram_waddr = g_q;
          ram_wdata = bayes_np;
          done_d    = 1'b1;
          status_d  = ogbu_pkg::ST_DONE;
          oidx_d    = IW'(g_q);
          oprob_d   = bayes_np;
          olast_d   = last_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pose_valid_q <= 1'b0;
      local_col_q  <= '0;
      local_row_q  <= '0;
      robot_x_q    <= '0;
      robot_y_q    <= '0;
      done_q       <= 1'b0;
      prob_occ_q   <= ogbu_pkg::PROB_OCC_RST;
      prob_emp_q   <= ogbu_pkg::PROB_EMP_RST;
    end else begin
      state_q      <= state_d;
      pose_valid_q <= pose_valid_d;
      local_col_q  <= local_col_d;
      local_row_q  <= local_row_d;
      robot_x_q    <= robot_x_d;
      robot_y_q    <= robot_y_d;
      done_q       <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == ogbu_pkg::CFG_PROB_OCC) begin
          prob_occ_q <= cfg_data_i;
        end else if (cfg_index_i == ogbu_pkg::CFG_PROB_EMP) begin
          prob_emp_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    gx_q     <= gx_d;
    gy_q     <= gy_d;
    sense_q  <= sense_d;
    last_q   <= last_d;
    g_q      <= g_d;
    cidx_q   <= cidx_d;
    status_q <= status_d;
    oidx_q   <= oidx_d;
    oprob_q  <= oprob_d;
    olast_q  <= olast_d;
  end

  ogbu_ram #(
    .WIDTH (ogbu_pkg::PROB_W),
    .DEPTH (GRID_CELLS)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ogbu_bayes u_bayes (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bayes_start),
    .p_i     (ram_rdata),
    .pa_i    (bayes_pa),
    .pb_i    (bayes_pb),
    .done_o  (bayes_done),
    .np_o    (bayes_np)
  );

  assign busy        = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign out_index_o = oidx_q;
  assign out_prob_o  = oprob_q;
  assign scan_last_o = olast_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bayes_done |-> state_q == S_WAIT)
    else $error("Bayes result outside write-back state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_IDLE || state_q == S_WAIT))
    else $error("grid written in a wrong state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDOUT || (state_q == S_WAIT && bayes_done)) |=> done_o)
    else $error("result strobe missing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == ogbu_pkg::CMD_LOCAL && pose_valid_q) |=> state_q == S_INDEX)
    else $error("local cell not taken into index stage");

endmodule

[design/ogbu_ram.sv]
// ----------------------------------------------------------------------------
// ogbu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ogbu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/ogbu_bayes.sv]
// ----------------------------------------------------------------------------
// ogbu_bayes
// Sequenced Bayes update p' = Pa*p / (Pa*p + Pb*(1-p)), rounded, saturated.
// One shared multiplier used twice, then a restoring divider, one bit a cycle.
// ----------------------------------------------------------------------------
module ogbu_bayes (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ogbu_pkg::prob_t p_i,
  input  ogbu_pkg::prob_t pa_i,
  input  ogbu_pkg::prob_t pb_i,
  output logic          done_o,
  output ogbu_pkg::prob_t np_o
);

  localparam int PW    = ogbu_pkg::PROB_W;
  localparam int MUL_W = PW + 1;          // operand width, holds 1.0 - p
  localparam int NUM_W = 2 * PW;          // Pa*p and Pb*(1-p) both fit
  localparam int DEN_W = 2 * PW + 1;
  localparam int DIV_W = NUM_W + PW + 1;  // num*2^16 + den/2
  localparam int Q_W   = PW + 1;          // quotient never exceeds 2^16
  localparam int CNT_W = $clog2(Q_W);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MULA = 3'd1;
  localparam logic [2:0] B_MULB = 3'd2;
  localparam logic [2:0] B_SUM  = 3'd3;
  localparam logic [2:0] B_PREP = 3'd4;
  localparam logic [2:0] B_DIV  = 3'd5;
  localparam logic [2:0] B_DONE = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] step_q, step_d;
  ogbu_pkg::prob_t  p_q, pa_q, pb_q;
  logic [NUM_W-1:0] num_q, num_d, nb_q, nb_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [Q_W-1:0]   sh_q, sh_d;

  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;
  logic [DIV_W-1:0]   dvd;
  logic [DEN_W:0]     trial;
  logic               fits;

  // Shared multiplier
  always_comb begin
    if (state_q == B_MULA) begin
      mul_a = MUL_W'(pa_q);
      mul_b = MUL_W'(p_q);
    end else begin
      mul_a = MUL_W'(pb_q);
      mul_b = MUL_W'(1 << PW) - MUL_W'(p_q);
    end
    mul_p = mul_a * mul_b;
  end

  assign dvd   = {num_q, PW'(0)} + DIV_W'(den_q >> 1);
  assign trial = {rem_q, sh_q[Q_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    num_d   = num_q;
    nb_d    = nb_q;
    den_d   = den_q;
    rem_d   = rem_q;
    sh_d    = sh_q;
    case (state_q)
      B_IDLE: begin
        if (start_i) begin
          state_d = B_MULA;
        end
      end
      B_MULA: begin
        num_d   = NUM_W'(mul_p);
        state_d = B_MULB;
      end
      B_MULB: begin
        nb_d    = NUM_W'(mul_p);
        state_d = B_SUM;
      end
      B_SUM: begin
        den_d   = DEN_W'(num_q) + DEN_W'(nb_q);
        state_d = B_PREP;
      end
      B_PREP: begin
        // quotient < 2^17, so the top of the dividend is already below den
        rem_d   = DEN_W'(dvd[DIV_W-1:Q_W]);
        sh_d    = dvd[Q_W-1:0];
        step_d  = CNT_W'(Q_W - 1);
        state_d = B_DIV;
      end
      B_DIV: begin
        rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
        sh_d  = {sh_q[Q_W-2:0], fits};
        if (step_q == '0) begin
          state_d = B_DONE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      B_DONE: begin
        state_d = B_IDLE;
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && start_i) begin
      p_q  <= p_i;
      pa_q <= pa_i;
      pb_q <= pb_i;
    end
    num_q <= num_d;
    nb_q  <= nb_d;
    den_q <= den_d;
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  // Zero denominator keeps the prior; quotient of 2^16 saturates.
  assign done_o = state_q == B_DONE;
  assign np_o   = (den_q == '0)     ? p_q :
                  sh_q[Q_W-1]       ? '1  : sh_q[PW-1:0];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == B_IDLE)
    else $error("bayes unit started while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> state_q == B_MULA)
    else $error("bayes start not taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV && step_q == '0) |=> done_o)
    else $error("divider did not finish after last step");

endmodule
